/* rtl/core/sbv_pkg.sv */
// Shared types, constants and constant tables for the sphere band vertex generator.
// Depends on nothing; every other file imports it.
package sbv_pkg;

    localparam int MAX_SLICES   = 64;
    localparam int MAX_STACKS   = 32;
    localparam int QUARTER_TURN = 23040;
    localparam int FULL_TURN    = 92160;
    localparam int DIV_SHIFT    = 24;

    localparam int FRONT_LAT  = 5;
    localparam int SINE_LAT   = 11;
    localparam int VERTEX_LAT = 3;
    localparam int PIPE_LAT   = FRONT_LAT + SINE_LAT + VERTEX_LAT;

    localparam int OUT_DEPTH = 32;
    localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
    localparam int CREDIT_W  = $clog2(OUT_DEPTH + 1);

    localparam logic [30:0] K1 = 31'd1686629713;
    localparam logic [29:0] K3 = 30'd693598668;
    localparam logic [26:0] K5 = 27'd85569306;
    localparam logic [22:0] K7 = 23'd5026995;
    localparam logic [17:0] K9 = 18'd172272;

    localparam logic [15:0] RECIP_45 = 16'd46604;

    typedef logic signed [17:0] angle_t;
    typedef logic signed [16:0] trig_t;

    localparam angle_t ANGLE_QUARTER = 18'(QUARTER_TURN);
    localparam angle_t ANGLE_FULL    = 18'(FULL_TURN);
    localparam logic signed [15:0] ALT_LIMIT = 16'(QUARTER_TURN);

    typedef enum logic [2:0] {
        REG_SLICE_COUNT = 3'd0,
        REG_STACK_COUNT = 3'd1,
        REG_BOTTOM_ALT  = 3'd2,
        REG_TOP_ALT     = 3'd3,
        REG_RADIUS      = 3'd4
    } reg_addr_t;

    typedef struct packed {
        logic [6:0]         slice_count;
        logic [5:0]         stack_count;
        logic signed [15:0] bottom_alt;
        logic signed [15:0] top_alt;
        logic [15:0]        sphere_radius;
    } cfg_t;

    typedef struct packed {
        logic [15:0] tex_s;
        logic [15:0] tex_t;
        logic        last_vertex;
    } side_t;

    typedef struct packed {
        angle_t rho;
        angle_t rho_cos;
        angle_t theta;
        angle_t theta_cos;
        side_t  side;
    } front_out_t;

    typedef struct packed {
        trig_t       pos_x;
        trig_t       pos_y;
        trig_t       pos_z;
        logic [15:0] tex_s;
        logic [15:0] tex_t;
        logic        last_vertex;
    } vertex_t;

    typedef logic [DIV_SHIFT-1:0] recip_tbl_t [0:MAX_SLICES];
    typedef logic [20:0] frac_tbl_t [0:44];

    // long division of 2^(DIV_SHIFT-1) by d, one quotient bit per step
    function automatic logic [DIV_SHIFT-1:0] recip_entry(int d);
        logic [DIV_SHIFT-1:0] q;
        int                   rem;
        q   = '0;
        rem = 0;
        for (int b = DIV_SHIFT - 1; b >= 0; b--)
        begin
            rem = (rem << 1) + ((b == DIV_SHIFT - 1) ? 1 : 0);
            if (rem >= d)
            begin
                rem  = rem - d;
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic recip_tbl_t build_recip();
        recip_tbl_t t;
        t[0] = '0;
        for (int d = 1; d <= MAX_SLICES; d++)
        begin
            t[d] = recip_entry(d);
        end
        return t;
    endfunction

    function automatic frac_tbl_t build_frac45();
        frac_tbl_t t;
        for (int i = 0; i < 45; i++)
        begin
            t[i] = 21'((64'(i) << 21) / 45);
        end
        return t;
    endfunction

    localparam recip_tbl_t RECIP_TBL  = build_recip();
    localparam frac_tbl_t  FRAC45_TBL = build_frac45();

endpackage

/* rtl/core/sphere_band_vertex_generator_unit.sv */
// Sphere band vertex generator: each input transaction (stack, slice) yields two
// vertex transactions, lower edge first (tlast low), then upper edge (tlast high).
// One vertex enters the pipeline per clock while issue credit lasts; a new input
// item is taken as the upper-edge vertex issues or when the holding register is empty.
// The pipeline has 5 angle/divide, 11 sine and 3 position stages and 1 buffer write.
// A 32-entry output buffer with issue credits decouples the two sides: input keeps
// flowing during output stalls until the buffer's reserved space runs out. The user
// must write configuration over APB only while idle (unenforced); a write takes effect
// for items accepted from the next cycle on. No clearing pass is needed after reset.
// Depends on sbv_pkg, sbv_front, sbv_sine, sbv_vertex and sbv_fifo.
module sphere_band_vertex_generator_unit
    import sbv_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [4:0] stack_index, [11:5] slice_index
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [87:0] m_tdata,   // [16:0] pos_x, [33:17] pos_y, [50:34] pos_z,
                                   // [66:51] tex_s, [82:67] tex_t
    output logic        m_tlast    // last_vertex
);

    logic [6:0]         slice_count_reg;
    logic [5:0]         stack_count_reg;
    logic signed [15:0] bottom_alt_reg;
    logic signed [15:0] top_alt_reg;
    logic [15:0]        radius_reg;
    logic               wr;
    cfg_t               cfg;

    logic                issue, issue_ok, pop;
    logic [CREDIT_W-1:0] credit_reg, credit_next;
    logic [PIPE_LAT-1:0] vld_reg;
    front_out_t          vtx;
    trig_t               sin_rho, cos_rho, sin_theta, cos_theta;
    side_t               side_dly_reg [SINE_LAT];
    vertex_t             vert, out_item;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slice_count_reg <= 7'd20;
            stack_count_reg <= 6'd10;
            bottom_alt_reg  <= -16'sd23040;
            top_alt_reg     <= 16'sd23040;
            radius_reg      <= 16'd256;
        end
        else if (wr)
        begin
            unique case (paddr[4:2])
                REG_SLICE_COUNT: slice_count_reg <= pwdata[6:0];
                REG_STACK_COUNT: stack_count_reg <= pwdata[5:0];
                REG_BOTTOM_ALT:  bottom_alt_reg  <= pwdata[15:0];
                REG_TOP_ALT:     top_alt_reg     <= pwdata[15:0];
                REG_RADIUS:      radius_reg      <= pwdata[15:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[4:2])
            REG_SLICE_COUNT: prdata = {25'd0, slice_count_reg};
            REG_STACK_COUNT: prdata = {26'd0, stack_count_reg};
            REG_BOTTOM_ALT:  prdata = 32'(bottom_alt_reg);
            REG_TOP_ALT:     prdata = 32'(top_alt_reg);
            REG_RADIUS:      prdata = {16'd0, radius_reg};
            default:         prdata = '0;
        endcase
    end

    always_comb
    begin
        cfg.slice_count   = slice_count_reg;
        cfg.stack_count   = stack_count_reg;
        cfg.bottom_alt    = bottom_alt_reg;
        cfg.top_alt       = top_alt_reg;
        cfg.sphere_radius = radius_reg;
    end

    // reserve buffer space for every vertex in flight
    assign issue_ok    = credit_reg < CREDIT_W'(OUT_DEPTH);
    assign pop         = m_tvalid && m_tready;
    assign credit_next = credit_reg + CREDIT_W'(issue) - CREDIT_W'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            credit_reg <= '0;
            vld_reg    <= '0;
        end
        else
        begin
            credit_reg <= credit_next;
            vld_reg    <= {vld_reg[PIPE_LAT-2:0], issue};
        end
    end

    sbv_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .issue_ok (issue_ok),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .issue    (issue),
        .vtx      (vtx)
    );

    sbv_sine u_sin_rho   (.clk(clk), .angle(vtx.rho),       .value(sin_rho));
    sbv_sine u_cos_rho   (.clk(clk), .angle(vtx.rho_cos),   .value(cos_rho));
    sbv_sine u_sin_theta (.clk(clk), .angle(vtx.theta),     .value(sin_theta));
    sbv_sine u_cos_theta (.clk(clk), .angle(vtx.theta_cos), .value(cos_theta));

    always_ff @(posedge clk)
    begin
        side_dly_reg[0] <= vtx.side;
        for (int i = 1; i < SINE_LAT; i++)
        begin
            side_dly_reg[i] <= side_dly_reg[i-1];
        end
    end

    sbv_vertex u_vertex (
        .clk       (clk),
        .sin_rho   (sin_rho),
        .cos_rho   (cos_rho),
        .sin_theta (sin_theta),
        .cos_theta (cos_theta),
        .radius    (radius_reg),
        .side      (side_dly_reg[SINE_LAT-1]),
        .result    (vert)
    );

    sbv_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (vld_reg[PIPE_LAT-1]),
        .push_data (vert),
        .pop_valid (m_tvalid),
        .pop_ready (m_tready),
        .pop_data  (out_item)
    );

    assign m_tdata = {5'd0, out_item.tex_t, out_item.tex_s,
                      out_item.pos_z, out_item.pos_y, out_item.pos_x};
    assign m_tlast = out_item.last_vertex;

    a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        credit_reg <= CREDIT_W'(OUT_DEPTH))
        else $error("issue credit above buffer depth");

    a_inflight_covered: assert property (@(posedge clk) disable iff (!rst_n)
        CREDIT_W'($countones(vld_reg)) <= credit_reg)
        else $error("vertex in flight without credit");

    a_output_credit: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (credit_reg != '0))
        else $error("output transaction pending without credit");

    a_issue_space: assert property (@(posedge clk) disable iff (!rst_n)
        issue |=> (credit_reg != '0))
        else $error("issue did not take a credit");

endmodule

/* rtl/core/sbv_front.sv */
// Input holding register, vertex expansion and angle/texture computation (five stages).
// Depends on sbv_pkg.
module sbv_front
    import sbv_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_t       cfg,
    input  logic       issue_ok,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [15:0] s_tdata,   // [4:0] stack_index, [11:5] slice_index
    output logic       issue,
    output front_out_t vtx
);

    logic [6:0]         slices_c;
    logic [5:0]         stacks_c;
    logic signed [15:0] bot_c, top_c;

    logic [6:0]           slices_reg;
    logic [5:0]           stacks_reg;
    logic signed [15:0]   bot_reg;
    logic signed [16:0]   dif_reg;
    logic [DIV_SHIFT-1:0] inv_sl_reg, inv_st_reg;

    logic       item_v_reg, item_v_next;
    logic       phase_reg, phase_next;
    logic [4:0] stack_reg;
    logic [6:0] slice_reg;
    logic       accept;

    logic [4:0] stk_c;
    logic [6:0] slc_c;
    logic [5:0] level_a_reg;
    logic [6:0] slice_a_reg;
    logic       wrap_a_reg, last_a_reg;

    logic [15:0]          dmag;
    logic [DIV_SHIFT-1:0] n_b_reg [4];
    logic                 wrap_b_reg, last_b_reg;

    logic [DIV_SHIFT-1:0] n_c_reg [4];
    logic [16:0]          q0_c_reg [4];
    logic                 wrap_c_reg, last_c_reg;
    logic [7:0]           div_w [4];
    logic [DIV_SHIFT-1:0] inv_w [4];

    logic [16:0] q_d_reg [4];
    logic        wrap_d_reg, last_d_reg;

    logic signed [17:0] step_s, rho_s, theta_s;
    front_out_t         vtx_reg;

    always_comb
    begin
        if (cfg.slice_count == '0)
            slices_c = 7'd1;
        else if (cfg.slice_count > 7'(MAX_SLICES))
            slices_c = 7'(MAX_SLICES);
        else
            slices_c = cfg.slice_count;
        if (cfg.stack_count == '0)
            stacks_c = 6'd1;
        else if (cfg.stack_count > 6'(MAX_STACKS))
            stacks_c = 6'(MAX_STACKS);
        else
            stacks_c = cfg.stack_count;
        if (cfg.bottom_alt > ALT_LIMIT)
            bot_c = ALT_LIMIT;
        else if (cfg.bottom_alt < -ALT_LIMIT)
            bot_c = -ALT_LIMIT;
        else
            bot_c = cfg.bottom_alt;
        if (cfg.top_alt > ALT_LIMIT)
            top_c = ALT_LIMIT;
        else if (cfg.top_alt < -ALT_LIMIT)
            top_c = -ALT_LIMIT;
        else
            top_c = cfg.top_alt;
    end

    always_ff @(posedge clk)
    begin
        slices_reg <= slices_c;
        stacks_reg <= stacks_c;
        bot_reg    <= bot_c;
        dif_reg    <= 17'(top_c) - 17'(bot_c);
        inv_sl_reg <= RECIP_TBL[slices_c];
        inv_st_reg <= RECIP_TBL[{1'b0, stacks_c}];
    end

    assign issue    = item_v_reg && issue_ok;
    assign s_tready = !item_v_reg || (phase_reg && issue_ok);
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        item_v_next = item_v_reg;
        phase_next  = phase_reg;
        if (issue)
        begin
            phase_next = !phase_reg;
            if (phase_reg)
                item_v_next = 1'b0;
        end
        if (accept)
        begin
            item_v_next = 1'b1;
            phase_next  = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_v_reg <= 1'b0;
            phase_reg  <= 1'b0;
        end
        else
        begin
            item_v_reg <= item_v_next;
            phase_reg  <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stack_reg <= s_tdata[4:0];
            slice_reg <= s_tdata[11:5];
        end
    end

    // stage A: clamp indices, pick edge
    always_comb
    begin
        stk_c = ({1'b0, stack_reg} >= stacks_reg) ? 5'(stacks_reg - 6'd1) : stack_reg;
        slc_c = (slice_reg > slices_reg) ? slices_reg : slice_reg;
    end

    always_ff @(posedge clk)
    begin
        level_a_reg <= 6'(stk_c) + 6'(phase_reg);
        slice_a_reg <= slc_c;
        wrap_a_reg  <= (slc_c == slices_reg);
        last_a_reg  <= phase_reg;
    end

    // stage B: numerators
    assign dmag = 16'(dif_reg[16] ? -dif_reg : dif_reg);

    always_ff @(posedge clk)
    begin
        n_b_reg[0] <= DIV_SHIFT'(slice_a_reg) * DIV_SHIFT'(184320) + DIV_SHIFT'(slices_reg);
        n_b_reg[1] <= (DIV_SHIFT'(slice_a_reg) << 16) + DIV_SHIFT'(slices_reg);
        n_b_reg[2] <= ((DIV_SHIFT'(level_a_reg) * DIV_SHIFT'(dmag)) << 1)
                      + DIV_SHIFT'(stacks_reg);
        n_b_reg[3] <= (DIV_SHIFT'(level_a_reg) << 16) + DIV_SHIFT'(stacks_reg);
        wrap_b_reg <= wrap_a_reg;
        last_b_reg <= last_a_reg;
    end

    // stage C: reciprocal multiply
    always_comb
    begin
        div_w[0] = {slices_reg, 1'b0};
        div_w[1] = {slices_reg, 1'b0};
        div_w[2] = {1'b0, stacks_reg, 1'b0};
        div_w[3] = {1'b0, stacks_reg, 1'b0};
        inv_w[0] = inv_sl_reg;
        inv_w[1] = inv_sl_reg;
        inv_w[2] = inv_st_reg;
        inv_w[3] = inv_st_reg;
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 4; i++)
        begin
            n_c_reg[i]  <= n_b_reg[i];
            q0_c_reg[i] <= 17'(((2*DIV_SHIFT)'(n_b_reg[i]) * (2*DIV_SHIFT)'(inv_w[i]))
                               >> DIV_SHIFT);
        end
        wrap_c_reg <= wrap_b_reg;
        last_c_reg <= last_b_reg;
    end

    // stage D: one-step correction
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 4; i++)
        begin
            if ((25'(n_c_reg[i]) - 25'(q0_c_reg[i]) * 25'(div_w[i])) >= 25'(div_w[i]))
                q_d_reg[i] <= q0_c_reg[i] + 17'd1;
            else
                q_d_reg[i] <= q0_c_reg[i];
        end
        wrap_d_reg <= wrap_c_reg;
        last_d_reg <= last_c_reg;
    end

    // stage E: angles and texture coordinates
    always_comb
    begin
        step_s  = signed'(18'(q_d_reg[2]));
        if (dif_reg[16])
            step_s = -step_s;
        rho_s   = ANGLE_QUARTER + 18'(bot_reg) + step_s;
        theta_s = wrap_d_reg ? 18'sd0 : signed'(18'(q_d_reg[0]));
    end

    always_ff @(posedge clk)
    begin
        vtx_reg.rho              <= rho_s;
        vtx_reg.rho_cos          <= rho_s + ANGLE_QUARTER;
        vtx_reg.theta            <= theta_s;
        vtx_reg.theta_cos        <= theta_s + ANGLE_QUARTER;
        vtx_reg.side.tex_s       <= 16'(17'd32768 - q_d_reg[1]);
        vtx_reg.side.tex_t       <= 16'(q_d_reg[3]);
        vtx_reg.side.last_vertex <= last_d_reg;
    end

    assign vtx = vtx_reg;

endmodule

/* rtl/core/sbv_sine.sv */
// Pipelined Q1.15 sine of an angle in 1/256 degree units (eleven stages).
// Depends on sbv_pkg.
module sbv_sine
    import sbv_pkg::*;
(
    input  logic   clk,
    input  angle_t angle,
    output trig_t  value
);

    angle_t      m_c;
    logic [16:0] m1_reg;
    logic [1:0]  q_c;
    logic [16:0] base_c;
    logic [14:0] r_c;
    logic [14:0] rf2_reg, rf3_reg;
    logic        neg2_reg, neg3_reg, neg4_reg, neg5_reg, neg6_reg;
    logic        neg7_reg, neg8_reg, neg9_reg, neg10_reg;
    logic [30:0] prod3_reg;
    logic [9:0]  qr_c;
    logic [5:0]  rr_c;
    logic [30:0] u4_reg, u5_reg, u6_reg, u7_reg, u8_reg, u9_reg;
    logic [30:0] u2_5_reg, u2_6_reg, u2_7_reg, u2_8_reg;
    logic [22:0] p6_reg;
    logic [26:0] p7_reg;
    logic [29:0] p8_reg;
    logic [30:0] p9_reg;
    logic [30:0] s10_reg;
    logic [16:0] rnd_c;
    logic [15:0] mag_c;
    trig_t       value_reg;

    // stage 1: reduce to one turn
    always_comb
    begin
        if (angle < 18'sd0)
            m_c = angle + ANGLE_FULL;
        else if (angle >= ANGLE_FULL)
            m_c = angle - ANGLE_FULL;
        else
            m_c = angle;
    end

    always_ff @(posedge clk)
    begin
        m1_reg <= 17'(m_c);
    end

    // stage 2: fold to quarter wave
    always_comb
    begin
        if (m1_reg >= 17'(3 * QUARTER_TURN))
            q_c = 2'd3;
        else if (m1_reg >= 17'(2 * QUARTER_TURN))
            q_c = 2'd2;
        else if (m1_reg >= 17'(QUARTER_TURN))
            q_c = 2'd1;
        else
            q_c = 2'd0;
        unique case (q_c)
            2'd0: base_c = 17'd0;
            2'd1: base_c = 17'(QUARTER_TURN);
            2'd2: base_c = 17'(2 * QUARTER_TURN);
            2'd3: base_c = 17'(3 * QUARTER_TURN);
        endcase
        r_c = 15'(m1_reg - base_c);
    end

    always_ff @(posedge clk)
    begin
        rf2_reg  <= q_c[0] ? 15'(QUARTER_TURN) - r_c : r_c;
        neg2_reg <= q_c[1];
    end

    // stage 3: divide by 45 through reciprocal
    always_ff @(posedge clk)
    begin
        prod3_reg <= 31'(rf2_reg) * 31'(RECIP_45);
        rf3_reg   <= rf2_reg;
        neg3_reg  <= neg2_reg;
    end

    // stage 4: u = r * 2^30 / 23040
    always_comb
    begin
        qr_c = prod3_reg[30:21];
        rr_c = 6'(rf3_reg - 15'(qr_c) * 15'd45);
    end

    always_ff @(posedge clk)
    begin
        u4_reg   <= {qr_c, 21'd0} + 31'(FRAC45_TBL[rr_c]);
        neg4_reg <= neg3_reg;
    end

    // stage 5: u squared
    always_ff @(posedge clk)
    begin
        u2_5_reg <= 31'((62'(u4_reg) * 62'(u4_reg)) >> 30);
        u5_reg   <= u4_reg;
        neg5_reg <= neg4_reg;
    end

    // stages 6 to 9: Horner steps
    always_ff @(posedge clk)
    begin
        p6_reg   <= K7 - 23'((49'(K9) * 49'(u2_5_reg)) >> 30);
        u2_6_reg <= u2_5_reg;
        u6_reg   <= u5_reg;
        neg6_reg <= neg5_reg;

        p7_reg   <= K5 - 27'((54'(p6_reg) * 54'(u2_6_reg)) >> 30);
        u2_7_reg <= u2_6_reg;
        u7_reg   <= u6_reg;
        neg7_reg <= neg6_reg;

        p8_reg   <= K3 - 30'((58'(p7_reg) * 58'(u2_7_reg)) >> 30);
        u2_8_reg <= u2_7_reg;
        u8_reg   <= u7_reg;
        neg8_reg <= neg7_reg;

        p9_reg   <= K1 - 31'((61'(p8_reg) * 61'(u2_8_reg)) >> 30);
        u9_reg   <= u8_reg;
        neg9_reg <= neg8_reg;
    end

    // stage 10: final product
    always_ff @(posedge clk)
    begin
        s10_reg   <= 31'((62'(u9_reg) * 62'(p9_reg)) >> 30);
        neg10_reg <= neg9_reg;
    end

    // stage 11: round, cap, sign
    always_comb
    begin
        rnd_c = 17'((32'(s10_reg) + 32'd16384) >> 15);
        mag_c = (rnd_c > 17'd32768) ? 16'd32768 : 16'(rnd_c);
    end

    always_ff @(posedge clk)
    begin
        value_reg <= neg10_reg ? -signed'(17'(mag_c)) : signed'(17'(mag_c));
    end

    assign value = value_reg;

endmodule

/* rtl/core/sbv_vertex.sv */
// Position products, rounding and sign for one vertex (three stages).
// Depends on sbv_pkg.
module sbv_vertex
    import sbv_pkg::*;
(
    input  logic        clk,
    input  trig_t       sin_rho,
    input  trig_t       cos_rho,
    input  trig_t       sin_theta,
    input  trig_t       cos_theta,
    input  logic [15:0] radius,
    input  side_t       side,
    output vertex_t     result
);

    logic [15:0] asr, acr, ast, act;
    logic [30:0] px1_reg, py1_reg;
    logic [31:0] pz1_reg, pz2_reg;
    logic        nx1_reg, ny1_reg, nz1_reg, nx2_reg, ny2_reg, nz2_reg;
    side_t       side1_reg, side2_reg;
    logic [46:0] mx2_reg, my2_reg;
    logic [16:0] rx, ry, rz;
    vertex_t     result_reg;

    always_comb
    begin
        asr = 16'(sin_rho < 17'sd0 ? -sin_rho : sin_rho);
        acr = 16'(cos_rho < 17'sd0 ? -cos_rho : cos_rho);
        ast = 16'(sin_theta < 17'sd0 ? -sin_theta : sin_theta);
        act = 16'(cos_theta < 17'sd0 ? -cos_theta : cos_theta);
    end

    always_ff @(posedge clk)
    begin
        px1_reg   <= 31'(ast) * 31'(asr);
        py1_reg   <= 31'(act) * 31'(asr);
        pz1_reg   <= 32'(acr) * 32'(radius);
        nx1_reg   <= ((sin_theta < 17'sd0) == (sin_rho < 17'sd0))
                     && (sin_theta != '0) && (sin_rho != '0);
        ny1_reg   <= (cos_theta < 17'sd0) != (sin_rho < 17'sd0);
        nz1_reg   <= cos_rho > 17'sd0;
        side1_reg <= side;
    end

    always_ff @(posedge clk)
    begin
        mx2_reg   <= 47'(px1_reg) * 47'(radius);
        my2_reg   <= 47'(py1_reg) * 47'(radius);
        pz2_reg   <= pz1_reg;
        nx2_reg   <= nx1_reg;
        ny2_reg   <= ny1_reg;
        nz2_reg   <= nz1_reg;
        side2_reg <= side1_reg;
    end

    always_comb
    begin
        rx = 17'((48'(mx2_reg) + 48'h0000_2000_0000) >> 30);
        ry = 17'((48'(my2_reg) + 48'h0000_2000_0000) >> 30);
        rz = 17'((33'(pz2_reg) + 33'd16384) >> 15);
    end

    always_ff @(posedge clk)
    begin
        result_reg.pos_x       <= nx2_reg ? -signed'(rx) : signed'(rx);
        result_reg.pos_y       <= ny2_reg ? -signed'(ry) : signed'(ry);
        result_reg.pos_z       <= nz2_reg ? -signed'(rz) : signed'(rz);
        result_reg.tex_s       <= side2_reg.tex_s;
        result_reg.tex_t       <= side2_reg.tex_t;
        result_reg.last_vertex <= side2_reg.last_vertex;
    end

    assign result = result_reg;

endmodule

/* rtl/core/sbv_fifo.sv */
// Output buffer for finished vertices with a registered head entry; space is
// reserved ahead by the issue credit. Depends on sbv_pkg.
module sbv_fifo
    import sbv_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  vertex_t push_data,
    output logic    pop_valid,
    input  logic    pop_ready,
    output vertex_t pop_data
);

    vertex_t              mem [OUT_DEPTH];
    logic [OUT_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [OUT_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CREDIT_W-1:0]  count_reg, count_next;
    logic                 out_valid_reg, out_valid_next;
    vertex_t              out_data_reg;
    logic                 pop, out_free, load_mem, bypass, write_mem;

    assign pop_valid = out_valid_reg;
    assign pop_data  = out_data_reg;
    assign pop       = out_valid_reg && pop_ready;
    assign out_free  = !out_valid_reg || pop;
    assign load_mem  = (count_reg != '0) && out_free;
    assign bypass    = (count_reg == '0) && out_free && push;
    assign write_mem = push && !bypass;

    always_comb
    begin
        wr_ptr_next    = write_mem ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next    = load_mem ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next     = count_reg + CREDIT_W'(write_mem) - CREDIT_W'(load_mem);
        out_valid_next = load_mem || bypass || (out_valid_reg && !pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg    <= '0;
            rd_ptr_reg    <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            wr_ptr_reg    <= wr_ptr_next;
            rd_ptr_reg    <= rd_ptr_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (write_mem)
            mem[wr_ptr_reg] <= push_data;
        if (load_mem)
            out_data_reg <= mem[rd_ptr_reg];
        else if (bypass)
            out_data_reg <= push_data;
    end

endmodule
